### design/assert_macros.svh
// assertion macros shared by the console cell writer modules
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge outside reset
`define TCW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every clock edge, reset included
`define TCW_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### design/tcw_pkg.sv
// shared types and constants of the console cell writer
// no dependencies
package tcw_pkg;

  localparam int CharW   = 8;
  localparam int IndexW  = 11;
  localparam int DataW   = 16;
  localparam int ColorW  = 8;
  localparam int RowOutW = 5;
  localparam int ColOutW = 7;

  localparam logic [CharW-1:0]  NewlineCode = 8'd10;
  localparam logic [CharW-1:0]  SpaceCode   = 8'd32;
  localparam logic [DataW-1:0]  BlankCell   = 16'h0720;
  localparam logic [ColorW-1:0] ColorReset  = 8'd7;

  // entries in the command queue between front and back
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_READ,
    OP_READ_NONE
  } op_kind_e;

  typedef struct packed {
    op_kind_e               kind;
    logic [CharW-1:0]       char_code;
    logic [IndexW-1:0]      index;
  } cmd_t;

  typedef struct packed {
    logic                   valid;
    logic [DataW-1:0]       data;
    logic [RowOutW-1:0]     row;
    logic [ColOutW-1:0]     col;
    logic                   scrolled;
  } res_t;

endpackage

### design/text_console_cell_writer_core.sv
// done_o reports each item once executed: a put or newline from the idle state,
// a read from its read wait state, an item that scrolls after the row clear sweep
// the back end ends each command, read or scroll included, before it pops the next;
// a 2-entry command queue lets start be taken while the back end works
// reset: cursor to home, color to 7, then a sweep writes blank cells to all ROWS*COLUMNS
// cells (2000 at 80x25) while busy_o is high; results cannot be stalled
module text_console_cell_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // transaction request
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        action_i,
  input  logic [tcw_pkg::CharW-1:0]   char_code_i,
  input  logic [tcw_pkg::IndexW-1:0]  read_index_i,
  // color register write
  input  logic                        cfg_we_i,
  input  logic [tcw_pkg::ColorW-1:0]  cfg_wdata_i,
  // result strobe
  output logic                        done_o,
  output logic [tcw_pkg::DataW-1:0]   read_data_o,
  output logic [tcw_pkg::RowOutW-1:0] cursor_row_o,
  output logic [tcw_pkg::ColOutW-1:0] cursor_col_o,
  output logic                        scrolled_o
);
  import tcw_pkg::*;

  // color byte for put cells and for rows blanked by a scroll
  logic [ColorW-1:0] color_q;

  // front to queue
  logic push, full, init_busy;
  cmd_t push_cmd;

  // queue to back
  logic pop, empty;
  cmd_t head_cmd;

  // back to result ports
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= ColorReset;
    end else if (cfg_we_i) begin
      color_q <= cfg_wdata_i;
    end
  end

  // classify: put, newline, in-range read, out-of-range read
  tcw_front #(
    .CellCount (ROWS * COLUMNS)
  ) u_front (
    .start_i      (start_i),
    .busy_o       (busy_o),
    .action_i     (action_i),
    .char_code_i  (char_code_i),
    .read_index_i (read_index_i),
    .full_i       (full),
    .init_busy_i  (init_busy),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // decouples acceptance from execution
  tcw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (empty),
    .full_o  (full)
  );

  // screen memory is a ring of rows, a scroll moves the top pointer
  // and blanks one row instead of copying the whole screen
  tcw_back #(
    .Columns (COLUMNS),
    .Rows    (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .color_i     (color_q),
    .cmd_i       (head_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .init_busy_o (init_busy),
    .res_o       (res)
  );

  assign done_o       = res.valid;
  assign read_data_o  = res.data;
  assign cursor_row_o = res.row;
  assign cursor_col_o = res.col;
  assign scrolled_o   = res.scrolled;

endmodule

### design/tcw_front.sv
// front end: takes transactions and classifies them into commands
// depends on tcw_pkg
module tcw_front #(
  parameter int CellCount = 2000
) (
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      action_i,
  input  logic [tcw_pkg::CharW-1:0] char_code_i,
  input  logic [tcw_pkg::IndexW-1:0] read_index_i,
  input  logic                      full_i,
  input  logic                      init_busy_i,
  output logic                      push_o,
  output tcw_pkg::cmd_t             cmd_o
);
  import tcw_pkg::*;

  localparam int AddrW = $clog2(CellCount);
  localparam int CmpW  = ((AddrW > IndexW) ? AddrW : IndexW) + 1;

  logic in_range;

  assign in_range = CmpW'(read_index_i) < CmpW'(CellCount);

  always_comb begin
    cmd_o.char_code = char_code_i;
    cmd_o.index     = read_index_i;
    if (action_i) begin
      cmd_o.kind = in_range ? OP_READ : OP_READ_NONE;
    end else if (char_code_i == NewlineCode) begin
      cmd_o.kind = OP_NEWLINE;
    end else begin
      cmd_o.kind = OP_PUT;
    end
  end

  assign busy_o = full_i | init_busy_i;
  assign push_o = start_i & ~busy_o;

endmodule

### design/tcw_queue.sv
// short command queue between front and back
// depends on tcw_pkg and assert_macros.svh
module tcw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcw_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output tcw_pkg::cmd_t cmd_o,
  output logic          empty_o,
  output logic          full_o
);
  import tcw_pkg::*;
  `include "assert_macros.svh"

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign empty_o = count_q == '0;
  assign full_o  = count_q == CntW'(QueueDepth);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  `TCW_ASSERT(a_count_bound, count_q <= CntW'(QueueDepth), "queue count overflow")
  `TCW_ASSERT(a_no_underflow, pop_i |-> !empty_o, "pop from empty queue")
  `TCW_ASSERT(a_no_overflow, push_i |-> !full_o, "push into full queue")

endmodule

### design/tcw_back.sv
// back end: cursor, ring-ordered screen memory, scroll and clearing sweeps
// depends on tcw_pkg and assert_macros.svh
module tcw_back #(
  parameter int Columns = 80,
  parameter int Rows    = 25
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tcw_pkg::ColorW-1:0] color_i,
  input  tcw_pkg::cmd_t              cmd_i,
  input  logic                       empty_i,
  output logic                       pop_o,
  output logic                       init_busy_o,
  output tcw_pkg::res_t              res_o
);
  import tcw_pkg::*;
  `include "assert_macros.svh"

  localparam int Cells = Rows * Columns;
  localparam int AddrW = $clog2(Cells);
  localparam int RowW  = $clog2(Rows);
  localparam int ColW  = $clog2(Columns);
  localparam logic [RowW-1:0]  LastRow  = RowW'(Rows - 1);
  localparam logic [ColW-1:0]  LastCol  = ColW'(Columns - 1);
  localparam logic [AddrW-1:0] LastCell = AddrW'(Cells - 1);
  localparam logic [AddrW-1:0] RowStep  = AddrW'(Columns);

  typedef enum logic [1:0] {
    ST_CLEAR_ALL,
    ST_IDLE,
    ST_READ_WAIT,
    ST_CLEAR_ROW
  } state_e;

  state_e           state_q;
  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [AddrW-1:0] top_q;
  logic [AddrW-1:0] ptr_q;
  logic [ColW-1:0]  cnt_q;
  logic [DataW-1:0] rd_q;
  res_t             res_q;

  logic [DataW-1:0] mem [Cells];

  logic             adv_row, at_last, scroll;
  logic [AddrW-1:0] put_addr, rd_addr;
  logic             rd_en, we;
  logic [AddrW-1:0] waddr;
  logic [DataW-1:0] wdata;

  // a + b where both are below Cells, folded back into the ring
  function automatic logic [AddrW-1:0] ring_add(input logic [AddrW-1:0] a,
                                                input logic [AddrW-1:0] b);
    logic [AddrW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (AddrW+1)'(Cells)) begin
      sum = sum - (AddrW+1)'(Cells);
    end
    return sum[AddrW-1:0];
  endfunction

  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign init_busy_o = state_q == ST_CLEAR_ALL;
  assign res_o       = res_q;

  always_comb begin
    adv_row  = (cmd_i.kind == OP_NEWLINE) || (col_q == LastCol);
    at_last  = row_q == LastRow;
    scroll   = adv_row && at_last;
    col_d    = adv_row ? '0 : col_q + 1'b1;
    row_d    = (adv_row && !at_last) ? row_q + 1'b1 : row_q;
    base_d   = (adv_row && !at_last) ? base_q + RowStep : base_q;
    put_addr = ring_add(base_q + AddrW'(col_q), top_q);
    rd_addr  = ring_add(AddrW'(cmd_i.index), top_q);
    rd_en    = pop_o && (cmd_i.kind == OP_READ);
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = BlankCell;
    case (state_q)
      ST_CLEAR_ALL: begin
        we = 1'b1;
      end
      ST_IDLE: begin
        we    = pop_o && (cmd_i.kind == OP_PUT);
        waddr = put_addr;
        wdata = {color_i, cmd_i.char_code};
      end
      ST_CLEAR_ROW: begin
        we    = 1'b1;
        wdata = {color_i, SpaceCode};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR_ALL;
      row_q     <= '0;
      col_q     <= '0;
      base_q    <= '0;
      top_q     <= '0;
      ptr_q     <= '0;
      cnt_q     <= '0;
      res_q     <= '0;
    end else begin
      case (state_q)
        ST_CLEAR_ALL: begin
          res_q.valid <= 1'b0;
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == LastCell) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop_o) begin
            case (cmd_i.kind)
              OP_READ: begin
                res_q.valid <= 1'b0;
                state_q     <= ST_READ_WAIT;
              end
              OP_READ_NONE: begin
                res_q.valid    <= 1'b1;
                res_q.data     <= '0;
                res_q.row      <= RowOutW'(row_q);
                res_q.col      <= ColOutW'(col_q);
                res_q.scrolled <= 1'b0;
              end
              default: begin
                row_q  <= row_d;
                col_q  <= col_d;
                base_q <= base_d;
                if (scroll) begin
                  // old top row becomes the new bottom row, blank it first
                  res_q.valid <= 1'b0;
                  ptr_q   <= top_q;
                  cnt_q   <= '0;
                  top_q   <= ring_add(top_q, RowStep);
                  state_q <= ST_CLEAR_ROW;
                end else begin
                  res_q.valid    <= 1'b1;
                  res_q.data     <= '0;
                  res_q.row      <= RowOutW'(row_d);
                  res_q.col      <= ColOutW'(col_d);
                  res_q.scrolled <= 1'b0;
                end
              end
            endcase
          end else begin
            res_q.valid <= 1'b0;
          end
        end
        ST_READ_WAIT: begin
          res_q.valid    <= 1'b1;
          res_q.data     <= rd_q;
          res_q.row      <= RowOutW'(row_q);
          res_q.col      <= ColOutW'(col_q);
          res_q.scrolled <= 1'b0;
          state_q        <= ST_IDLE;
        end
        ST_CLEAR_ROW: begin
          ptr_q <= ptr_q + 1'b1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LastCol) begin
            res_q.valid    <= 1'b1;
            res_q.data     <= '0;
            res_q.row      <= RowOutW'(row_q);
            res_q.col      <= ColOutW'(col_q);
            res_q.scrolled <= 1'b1;
            state_q        <= ST_IDLE;
          end else begin
            res_q.valid <= 1'b0;
          end
        end
        default: begin
          res_q.valid <= 1'b0;
          state_q     <= ST_IDLE;
        end
      endcase
    end
  end

  `TCW_ASSERT(a_cursor_range, (row_q <= LastRow) && (col_q <= LastCol),
              "cursor outside the screen")
  `TCW_ASSERT(a_no_result_in_init, (state_q == ST_CLEAR_ALL) |=> !res_q.valid,
              "result during reset clearing")
  `TCW_ASSERT(a_scroll_at_bottom,
              (res_q.valid && res_q.scrolled) |-> (row_q == LastRow) && (col_q == '0),
              "scroll result with cursor off the bottom row start")
  `TCW_ASSERT(a_read_wait_short,
              (state_q == ST_READ_WAIT) |=> (state_q == ST_IDLE) && res_q.valid,
              "read did not complete in one wait cycle")

endmodule

### sim/tb_top.sv
// self-checking testbench of text_console_cell_writer_core: table-driven directed items,
// then random phases under several text colors, checked against typed expectations or a cycle-free screen model
// depends on tcw_pkg and the core module from the design folder
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CellCount = ROWS * COLUMNS;

  // action codes on action_i
  localparam logic ActPut = 1'b0;
  localparam logic ActRead = 1'b1;

  localparam int NumDirected = 24;
  localparam int NumPhases = 6;
  localparam int ItemsPerPhase = 108;
  localparam int MaxReported = 10;
  localparam int MaxGap = 15;
  // far beyond the slowest legal run: ~850 items of max gap plus a full scroll each
  localparam longint TimeoutNs = 2_000_000;

  // one result of the core, as compared field by field
  typedef struct packed {
    logic [DataW-1:0] data;
    logic [RowOutW-1:0] row;
    logic [ColOutW-1:0] col;
    logic scrolled;
  } outcome_t;

  // one line of the directed table; count repeats the same item
  typedef struct packed {
    logic act;
    logic [CharW-1:0] ch;
    logic [IndexW-1:0] idx;
    logic [7:0] count;
    logic typed_in;
    outcome_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic action_i = 1'b0;
  logic [CharW-1:0] char_code_i = '0;
  logic [IndexW-1:0] read_index_i = '0;
  logic cfg_we_i = 1'b0;
  logic [ColorW-1:0] cfg_wdata_i = '0;
  logic done_o;
  logic [DataW-1:0] read_data_o;
  logic [RowOutW-1:0] cursor_row_o;
  logic [ColOutW-1:0] cursor_col_o;
  logic scrolled_o;

  // shadow copy of the screen, cursor and color register
  logic [DataW-1:0] shadow_screen [CellCount];
  int unsigned shadow_row;
  int unsigned shadow_col;
  logic [ColorW-1:0] shadow_color;

  // results predicted at acceptance, oldest first
  outcome_t pending_outcomes [$];
  int unsigned mismatch_cnt = 0;

  // directed table, written with the reset color 7
  // typed expectations only where they are obvious, the rest goes to the shadow model
  stim_row_t directed_rows [NumDirected] = '{
    // blank screen after reset, both ends of the cell range
    '{ActRead, 8'h00, 11'd0, 8'd1, 1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0}},
    '{ActRead, 8'h00, 11'd1999, 8'd1, 1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0}},
    // reads past the last cell give zero
    '{ActRead, 8'h00, 11'd2000, 8'd1, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    '{ActRead, 8'h00, 11'd2047, 8'd1, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    // plain puts, character extremes
    '{ActPut, 8'h41, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd0, 7'd1, 1'b0}},
    '{ActRead, 8'h00, 11'd0, 8'd1, 1'b1, '{16'h0741, 5'd0, 7'd1, 1'b0}},
    '{ActPut, 8'h00, 11'd2047, 8'd1, 1'b1, '{16'h0000, 5'd0, 7'd2, 1'b0}},
    '{ActPut, 8'hFF, 11'd1365, 8'd1, 1'b1, '{16'h0000, 5'd0, 7'd3, 1'b0}},
    '{ActRead, 8'hFF, 11'd2, 8'd1, 1'b1, '{16'h07FF, 5'd0, 7'd3, 1'b0}},
    // newline moves down and writes no cell
    '{ActPut, NewlineCode, 11'd682, 8'd1, 1'b1, '{16'h0000, 5'd1, 7'd0, 1'b0}},
    '{ActRead, 8'h00, 11'd3, 8'd1, 1'b1, '{16'h0720, 5'd1, 7'd0, 1'b0}},
    // a full line wraps the column to the next row
    '{ActPut, 8'h5A, 11'd0, 8'd80, 1'b0, '0},
    '{ActRead, 8'h00, 11'd159, 8'd1, 1'b0, '0},
    // walk down to the last row
    '{ActPut, NewlineCode, 11'd0, 8'd22, 1'b0, '0},
    '{ActPut, 8'h42, 11'd0, 8'd79, 1'b0, '0},
    // wrap on the last row scrolls and stays on that row
    '{ActPut, 8'h43, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd24, 7'd0, 1'b1}},
    '{ActRead, 8'h00, 11'd1919, 8'd1, 1'b0, '0},
    '{ActRead, 8'h00, 11'd1920, 8'd1, 1'b0, '0},
    '{ActRead, 8'h00, 11'd0, 8'd1, 1'b0, '0},
    '{ActPut, 8'h44, 11'd0, 8'd1, 1'b0, '0},
    // newline on the last row scrolls, column home, row kept
    '{ActPut, NewlineCode, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd24, 7'd0, 1'b1}},
    '{ActRead, 8'h00, 11'd1840, 8'd1, 1'b0, '0},
    '{ActRead, 8'h00, 11'd1920, 8'd1, 1'b0, '0},
    '{ActRead, 8'h00, 11'd1999, 8'd1, 1'b0, '0}
  };

  text_console_cell_writer_core #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .action_i(action_i),
    .char_code_i(char_code_i),
    .read_index_i(read_index_i),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o(done_o),
    .read_data_o(read_data_o),
    .cursor_row_o(cursor_row_o),
    .cursor_col_o(cursor_col_o),
    .scrolled_o(scrolled_o)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shift the shadow screen up one row and blank the bottom row in the current color
  function automatic void shadow_scroll();
    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
      shadow_screen[i] = shadow_screen[i + COLUMNS];
    end
    for (int i = (ROWS - 1) * COLUMNS; i < CellCount; i++) begin
      shadow_screen[i] = {shadow_color, SpaceCode};
    end
  endfunction

  // advance the shadow console by one transaction and return what the core should report
  function automatic outcome_t console_step(input logic act, input logic [CharW-1:0] ch,
                                            input logic [IndexW-1:0] idx);
    outcome_t res;
    int unsigned pos;
    res = '0;
    if (act == ActRead) begin
      if (idx < CellCount) begin
        res.data = shadow_screen[idx];
      end
    end else if (ch == NewlineCode) begin
      shadow_col = 0;
      if (shadow_row + 1 >= ROWS) begin
        shadow_scroll();
        res.scrolled = 1'b1;
        shadow_row = ROWS - 1;
      end else begin
        shadow_row++;
      end
    end else begin
      pos = shadow_row * COLUMNS + shadow_col;
      if (pos < CellCount) begin
        shadow_screen[pos] = {shadow_color, ch};
      end
      shadow_col++;
      if (shadow_col >= COLUMNS) begin
        shadow_col = 0;
        shadow_row++;
        // wrap past the bottom: scroll and keep the cursor on the last row
        if (shadow_row >= ROWS) begin
          shadow_scroll();
          res.scrolled = 1'b1;
          shadow_row = ROWS - 1;
        end
      end
    end
    res.row = shadow_row[RowOutW-1:0];
    res.col = shadow_col[ColOutW-1:0];
    return res;
  endfunction

  // present one transaction after a gap, hold it until taken, record its expected result
  // called and left at a falling edge
  task automatic apply_item(input logic act, input logic [CharW-1:0] ch,
                            input logic [IndexW-1:0] idx, input int unsigned gap,
                            input logic typed_in, input outcome_t typed_out);
    outcome_t predicted;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    action_i <= act;
    char_code_i <= ch;
    read_index_i <= idx;
    // taken at the first rising edge with busy low
    do begin
      @(posedge clk_i);
    end while (busy_o);
    predicted = console_step(act, ch, idx);
    pending_outcomes.push_back(typed_in ? typed_out : predicted);
    @(negedge clk_i);
  endtask

  // wait until every predicted result has come back, then return at a falling edge
  task automatic drain_results();
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // result checker: one strobe, one transaction, compared with the oldest prediction
  always @(posedge clk_i) begin : check_results
    outcome_t got;
    outcome_t want;
    if (rst_ni && done_o) begin
      got = '{read_data_o, cursor_row_o, cursor_col_o, scrolled_o};
      if (pending_outcomes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReported) begin
          $display("unexpected result: data %h row %0d col %0d scrolled %b",
                   got.data, got.row, got.col, got.scrolled);
        end
      end else begin
        want = pending_outcomes.pop_front();
        if (got.data !== want.data || got.row !== want.row || got.col !== want.col ||
            got.scrolled !== want.scrolled) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReported) begin
            $display("result mismatch at %0t: expected data %h row %0d col %0d scrolled %b,",
                     $realtime, want.data, want.row, want.col, want.scrolled);
            $display("  got data %h row %0d col %0d scrolled %b",
                     got.data, got.row, got.col, got.scrolled);
          end
        end
      end
    end
  end

  // main sequence
  initial begin : stimulus
    logic act;
    logic [CharW-1:0] ch;
    logic [IndexW-1:0] idx;
    int unsigned pick;
    int unsigned gap;
    bit no_gaps;
    int unsigned cur;

    // shadow state matches the core after reset
    for (int i = 0; i < CellCount; i++) begin
      shadow_screen[i] = BlankCell;
    end
    shadow_row = 0;
    shadow_col = 0;
    shadow_color = ColorReset;

    // reset held low, then released at a falling edge
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, the blanking sweep after reset is covered by waiting on busy
    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].count; k++) begin
        apply_item(directed_rows[r].act, directed_rows[r].ch, directed_rows[r].idx,
                   $urandom_range(0, MaxGap), directed_rows[r].typed_in,
                   directed_rows[r].want);
      end
    end

    // random phases, each under its own text color
    for (int phase = 0; phase < NumPhases; phase++) begin
      // color only changes with the core idle
      start_i <= 1'b0;
      drain_results();
      cfg_we_i <= 1'b1;
      case (phase)
        0: cfg_wdata_i <= 8'hFF;
        1: cfg_wdata_i <= 8'h00;
        default: cfg_wdata_i <= ColorW'($urandom_range(0, 255));
      endcase
      @(posedge clk_i);
      shadow_color = cfg_wdata_i;
      @(negedge clk_i);
      cfg_we_i <= 1'b0;

      // every third phase runs back to back with no sender gaps
      no_gaps = (phase % 3 == 1);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        pick = $urandom_range(0, 99);
        ch = CharW'($urandom_range(0, 255));
        idx = IndexW'($urandom_range(0, 2047));
        act = ActPut;
        if (pick < 55) begin
          // random character, an occasional newline code included
        end else if (pick < 72) begin
          ch = NewlineCode;
        end else if (pick < 80) begin
          // read back the cell just behind the cursor
          act = ActRead;
          cur = shadow_row * COLUMNS + shadow_col;
          idx = IndexW'((cur != 0) ? cur - 1 : 0);
        end else if (pick < 92) begin
          act = ActRead;
          idx = IndexW'($urandom_range(0, CellCount - 1));
        end else begin
          // beyond the last cell
          act = ActRead;
          idx = IndexW'($urandom_range(CellCount, 2047));
        end
        gap = no_gaps ? 0 : $urandom_range(0, MaxGap);
        apply_item(act, ch, idx, gap, 1'b0, '0);
      end
    end

    start_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    // room for a stray late result after a full row clear
    repeat (COLUMNS + 4) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #(TimeoutNs);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
